@@ src/swrr_pkg.sv @@
// Package for the SQL window rank / running aggregate block.
// Holds shared widths, mode codes, the queue entry type and helpers.
// No dependencies.
package swrr_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int ARG_W   = 32;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int MODE_W  = 3;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_ROW_NUM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RANK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DENSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUM     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AVG     = 3'd4;

    localparam logic [PADDR_W-1:0] ADDR_FUNC_MODE = 2'd0;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // One classified row on its way from front to back.
    typedef struct packed {
        logic              is_avg;   // needs the divider
        logic              is_null;
        logic [SUM_W-1:0]  value;    // final value, or running sum for average
        logic [CNT_W-1:0]  count;    // non-null count for average
    } entry_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        logic             ovf;
        s   = a + b;
        ovf = (a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1]);
        if (ovf)
        begin
            return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

endpackage

@@ src/swrr_ifs.sv @@
// Valid/ready channel interfaces for rows in and results out.
// Depends on swrr_pkg.
interface swrr_row_if;
    logic                            valid;
    logic                            ready;
    logic                            new_partition;
    logic                            is_peer;
    logic                            arg_null;
    logic signed [swrr_pkg::ARG_W-1:0] arg_value;

    modport source (output valid, output new_partition, output is_peer,
                    output arg_null, output arg_value, input ready);
    modport sink   (input valid, input new_partition, input is_peer,
                    input arg_null, input arg_value, output ready);
endinterface

interface swrr_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [swrr_pkg::SUM_W-1:0] result_value;
    logic                            result_null;

    modport source (output valid, output result_value, output result_null,
                    input ready);
    modport sink   (input valid, input result_value, input result_null,
                    output ready);
endinterface

@@ src/sql_window_rank_and_running_aggregate.sv @@
// Top level of the SQL window rank / running aggregate block.
// Depends on swrr_pkg, swrr_ifs, swrr_front, swrr_queue, swrr_back.

// Streams sorted rows and returns one result beat per row: row number, rank,
// dense rank, running sum or running average, chosen by func_mode (APB
// register at address 0; write it only while the block is idle). Sum and
// average skip null arguments and report null (value 0) until the first
// non-null one; the average is sum * 2^FRAC_BITS / count, truncated toward
// zero, saturated to signed 64 bits. Rate: for row number, rank, dense rank
// and sum the block takes one row per cycle while the queue is not full, and
// each result passes the queue and the output register. For the average the
// back end takes no new row until its one-bit-per-cycle restoring divider
// is done with the last one. A queue of QUEUE_DEPTH entries between the row
// front end and the back end lets rows keep arriving while a result waits.
module sql_window_rank_and_running_aggregate #(
    parameter int DATA_WIDTH  = swrr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = swrr_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = swrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    swrr_row_if.sink                     row,
    swrr_res_if.source                   result,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swrr_pkg::PADDR_W-1:0] paddr,
    input  logic [swrr_pkg::PDATA_W-1:0] pwdata,
    output logic [swrr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [swrr_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic                        cfg_wr;

    // queue links
    logic             q_push_valid;
    swrr_pkg::entry_t q_push_data;
    logic             q_full;
    logic             q_pop_valid;
    logic             q_pop_ready;
    swrr_pkg::entry_t q_pop_data;

    // ---------------- configuration register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == swrr_pkg::ADDR_FUNC_MODE);
    assign mode_next = cfg_wr ? pwdata[swrr_pkg::MODE_W-1:0] : mode_reg;
    assign prdata = (paddr == swrr_pkg::ADDR_FUNC_MODE) ? swrr_pkg::PDATA_W'(mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= swrr_pkg::MODE_ROW_NUM;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // ---------------- front: accumulators, one row per beat ----------------
    swrr_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row        (row),
        .func_mode  (mode_reg),
        .q_full     (q_full),
        .push_valid (q_push_valid),
        .push_data  (q_push_data)
    );

    // ---------------- queue between front and back ----------------
    swrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // ---------------- back: divider and output register ----------------
    swrr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_data  (q_pop_data),
        .pop_ready (q_pop_ready),
        .result    (result)
    );

    // ---------------- checks ----------------
    ap_null_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.result_null |-> result.result_value == '0)
        else $error("null result carries a nonzero value");

    ap_null_only_aggregate: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.result_null |-> mode_reg >= swrr_pkg::MODE_SUM)
        else $error("null result in a counting mode");

    ap_queue_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> q_pop_valid)
        else $error("queue full but empty");

endmodule

@@ src/swrr_front.sv @@
// Front end: accepts rows, updates the partition accumulators, and pushes
// one classified entry per row into the queue. Depends on swrr_pkg, swrr_ifs.
module swrr_front #(
    parameter int DATA_WIDTH = swrr_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    swrr_row_if.sink                    row,
    input  logic [swrr_pkg::MODE_W-1:0] func_mode,
    input  logic                        q_full,
    output logic                        push_valid,
    output swrr_pkg::entry_t            push_data
);

    logic [swrr_pkg::CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [swrr_pkg::CNT_W-1:0] rank_reg, rank_next;
    logic [swrr_pkg::CNT_W-1:0] dense_reg, dense_next;
    logic                       first_reg, first_next;
    logic [swrr_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                       have_reg, have_next;
    logic [swrr_pkg::CNT_W-1:0] nn_cnt_reg, nn_cnt_next;

    logic [swrr_pkg::CNT_W-1:0] rc0, rk0, dn0, nn0;
    logic [swrr_pkg::SUM_W-1:0] sum0, raw, arg_ext;
    logic                       first0, have0;
    logic                       accept;

    assign row.ready = !q_full;
    assign accept    = row.valid && !q_full;

    // low DATA_WIDTH bits of the argument, sign-extended
    assign raw     = {{(swrr_pkg::SUM_W-swrr_pkg::ARG_W){1'b0}}, row.arg_value};
    assign arg_ext = {{(swrr_pkg::SUM_W-DATA_WIDTH){raw[DATA_WIDTH-1]}},
                      raw[DATA_WIDTH-1:0]};

    always_comb
    begin
        // partition clear happens before the row is counted
        rc0    = row.new_partition ? '0   : row_cnt_reg;
        rk0    = row.new_partition ? '0   : rank_reg;
        dn0    = row.new_partition ? '0   : dense_reg;
        first0 = row.new_partition | first_reg;
        sum0   = row.new_partition ? '0   : sum_reg;
        have0  = row.new_partition ? 1'b0 : have_reg;
        nn0    = row.new_partition ? '0   : nn_cnt_reg;

        row_cnt_next = swrr_pkg::sat_inc(rc0);
        rank_next    = (!row.is_peer || row_cnt_next == swrr_pkg::CNT_W'(1))
                       ? row_cnt_next : rk0;
        dense_next   = (first0 || !row.is_peer) ? swrr_pkg::sat_inc(dn0) : dn0;
        first_next   = 1'b0;
        if (!row.arg_null)
        begin
            sum_next    = swrr_pkg::sat_add(sum0, arg_ext);
            have_next   = 1'b1;
            nn_cnt_next = swrr_pkg::sat_inc(nn0);
        end
        else
        begin
            sum_next    = sum0;
            have_next   = have0;
            nn_cnt_next = nn0;
        end
    end

    always_comb
    begin
        push_data = '0;
        case (func_mode)
            swrr_pkg::MODE_ROW_NUM:
            begin
                push_data.value = swrr_pkg::SUM_W'(row_cnt_next);
            end
            swrr_pkg::MODE_RANK:
            begin
                push_data.value = swrr_pkg::SUM_W'(rank_next);
            end
            swrr_pkg::MODE_DENSE:
            begin
                push_data.value = swrr_pkg::SUM_W'(dense_next);
            end
            swrr_pkg::MODE_SUM:
            begin
                push_data.is_null = !have_next;
                push_data.value   = have_next ? sum_next : '0;
            end
            swrr_pkg::MODE_AVG:
            begin
                push_data.is_avg  = 1'b1;
                push_data.is_null = !have_next;
                push_data.value   = have_next ? sum_next : '0;
                push_data.count   = nn_cnt_next;
            end
            default:
            begin
                push_data.is_null = 1'b1;
            end
        endcase
    end

    assign push_valid = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            rank_reg    <= '0;
            dense_reg   <= '0;
            first_reg   <= 1'b1;
            sum_reg     <= '0;
            have_reg    <= 1'b0;
            nn_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            row_cnt_reg <= row_cnt_next;
            rank_reg    <= rank_next;
            dense_reg   <= dense_next;
            first_reg   <= first_next;
            sum_reg     <= sum_next;
            have_reg    <= have_next;
            nn_cnt_reg  <= nn_cnt_next;
        end
    end

endmodule

@@ src/swrr_queue.sv @@
// Small FIFO of classified entries between front and back ends.
// Depends on swrr_pkg.
module swrr_queue #(
    parameter int DEPTH = swrr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  swrr_pkg::entry_t push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop_ready,
    output swrr_pkg::entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    swrr_pkg::entry_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/swrr_back.sv @@
// Back end: passes ready-made values, null averages too, to the output register,
// and runs the rest through a radix-2 restoring divider. Depends on swrr_pkg, swrr_ifs.
module swrr_back #(
    parameter int FRAC_BITS = swrr_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  swrr_pkg::entry_t pop_data,
    output logic             pop_ready,
    swrr_res_if.source       result
);

    localparam int DQ_W   = swrr_pkg::SUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DQ_W + 1);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } bk_state_t;

    bk_state_t                  state_reg, state_next;
    logic [DQ_W-1:0]            dq_reg, dq_next;
    logic [swrr_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [swrr_pkg::CNT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       neg_reg, neg_next;

    logic                       res_valid_reg, res_valid_next;
    logic [swrr_pkg::SUM_W-1:0] res_value_reg, res_value_next;
    logic                       res_null_reg, res_null_next;

    logic                       out_free, direct, load;
    logic [swrr_pkg::SUM_W-1:0] mag, limit, q64, avg;
    logic [swrr_pkg::CNT_W:0]   trial, diff;
    logic                       ge, over;

    assign out_free = !res_valid_reg || result.ready;
    assign direct   = !pop_data.is_avg || pop_data.is_null;
    assign pop_ready = (state_reg == BK_IDLE) && (out_free || !direct);

    assign mag   = pop_data.value[swrr_pkg::SUM_W-1] ? ('0 - pop_data.value)
                                                     : pop_data.value;
    // one quotient bit per step
    assign trial = {rem_reg, dq_reg[DQ_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    assign limit = neg_reg ? swrr_pkg::SUM_MIN : swrr_pkg::SUM_MAX;
    assign over  = (dq_reg > DQ_W'(limit));
    assign q64   = over ? limit : dq_reg[swrr_pkg::SUM_W-1:0];
    assign avg   = neg_reg ? ('0 - q64) : q64;

    always_comb
    begin
        state_next     = state_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        load           = 1'b0;
        res_value_next = res_value_reg;
        res_null_next  = res_null_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    if (direct)
                    begin
                        load           = 1'b1;
                        res_value_next = pop_data.is_null ? '0 : pop_data.value;
                        res_null_next  = pop_data.is_null;
                    end
                    else
                    begin
                        neg_next   = pop_data.value[swrr_pkg::SUM_W-1];
                        dq_next    = DQ_W'(mag) << FRAC_BITS;
                        rem_next   = '0;
                        div_next   = pop_data.count;
                        step_next  = STEP_W'(DQ_W);
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next  = ge ? diff[swrr_pkg::CNT_W-1:0] : trial[swrr_pkg::CNT_W-1:0];
                dq_next   = {dq_reg[DQ_W-2:0], ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    res_value_next = avg;
                    res_null_next  = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg        <= dq_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        step_reg      <= step_next;
        neg_reg       <= neg_next;
        res_value_reg <= res_value_next;
        res_null_reg  <= res_null_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.result_value = res_value_reg;
    assign result.result_null  = res_null_reg;

endmodule

@@ tb/tb_sql_window_rank_and_running_aggregate.sv @@
// Self-checking testbench for sql_window_rank_and_running_aggregate.
// Depends on swrr_pkg, swrr_ifs and the block's RTL; drives rows, APB mode
// writes and result backpressure, and checks every result beat in order.
module tb_sql_window_rank_and_running_aggregate;

    localparam int DW   = swrr_pkg::DATA_WIDTH_DEF;
    localparam int FRAC = swrr_pkg::FRAC_BITS_DEF;
    // Settle window after the final drain, sized from the average divider.
    localparam int SETTLE_CYCLES = 2 * (64 + FRAC + 2);

    // mode codes with no function behind them
    localparam logic [swrr_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [swrr_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [swrr_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [swrr_pkg::SUM_W-1:0] value;
        logic                       is_null;
    } result_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [swrr_pkg::PADDR_W-1:0] paddr;
    logic [swrr_pkg::PDATA_W-1:0] pwdata;
    logic [swrr_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    swrr_row_if row_ch ();
    swrr_res_if res_ch ();

    sql_window_rank_and_running_aggregate dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .row     (row_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Window function model: all functions tracked at once, mode picks one
    // ------------------------------------------------------------------
    logic [swrr_pkg::MODE_W-1:0] model_mode;
    logic [swrr_pkg::CNT_W-1:0]  rows_seen;     // row number within partition
    logic [swrr_pkg::CNT_W-1:0]  rank_now;
    logic [swrr_pkg::CNT_W-1:0]  dense_now;
    logic                        at_first_row;  // next row opens the partition
    logic [swrr_pkg::SUM_W-1:0]  running_sum;
    logic                        seen_value;    // a non-null argument has arrived
    logic [swrr_pkg::CNT_W-1:0]  values_seen;   // non-null count

    result_beat_t pending_results[$];
    int           fail_count = 0;

    function automatic void clear_partition_state();
        rows_seen    = '0;
        rank_now     = '0;
        dense_now    = '0;
        at_first_row = 1'b1;
        running_sum  = '0;
        seen_value   = 1'b0;
        values_seen  = '0;
    endfunction

    function automatic logic [swrr_pkg::CNT_W-1:0] bump(
        input logic [swrr_pkg::CNT_W-1:0] v);
        if (v == swrr_pkg::CNT_MAX)
        begin
            return v;
        end
        return v + swrr_pkg::CNT_W'(1);
    endfunction

    // Signed add that clamps at the 64-bit limits instead of wrapping.
    function automatic logic [swrr_pkg::SUM_W-1:0] add_clamped(
        input logic [swrr_pkg::SUM_W-1:0] a,
        input logic [swrr_pkg::SUM_W-1:0] b);
        logic [swrr_pkg::SUM_W-1:0] s;
        s = a + b;
        if (a[swrr_pkg::SUM_W-1] == b[swrr_pkg::SUM_W-1]
            && s[swrr_pkg::SUM_W-1] != a[swrr_pkg::SUM_W-1])
        begin
            return a[swrr_pkg::SUM_W-1] ? swrr_pkg::SUM_MIN : swrr_pkg::SUM_MAX;
        end
        return s;
    endfunction

    // Low DW bits of the argument, sign-extended to the accumulator width.
    function automatic logic [swrr_pkg::SUM_W-1:0] widen_arg(
        input logic [swrr_pkg::ARG_W-1:0] arg);
        logic signed [DW-1:0] low;
        low = arg[DW-1:0];
        return swrr_pkg::SUM_W'(low);
    endfunction

    // sum * 2^FRAC / count on magnitudes, truncated toward zero, clamped.
    function automatic logic [swrr_pkg::SUM_W-1:0] fixed_mean(
        input logic [swrr_pkg::SUM_W-1:0] total,
        input logic [swrr_pkg::CNT_W-1:0] cnt);
        logic                       neg;
        logic [swrr_pkg::SUM_W-1:0] mag;
        logic [swrr_pkg::SUM_W-1:0] lim;
        logic [swrr_pkg::SUM_W-1:0] div;
        logic [swrr_pkg::SUM_W-1:0] whole;
        logic [swrr_pkg::SUM_W-1:0] rem;
        logic [swrr_pkg::SUM_W-1:0] q;
        neg = total[swrr_pkg::SUM_W-1];
        mag = neg ? (swrr_pkg::SUM_W'(0) - total) : total;
        lim = neg ? swrr_pkg::SUM_MIN : swrr_pkg::SUM_MAX;
        div = swrr_pkg::SUM_W'(cnt);
        if (div == '0)
        begin
            return '0;
        end
        whole = mag / div;
        rem   = mag % div;
        if (whole > (lim >> FRAC))
        begin
            q = lim;
        end
        else
        begin
            q = (whole << FRAC) + ((rem << FRAC) / div);
            if (q > lim)
            begin
                q = lim;
            end
        end
        return neg ? (swrr_pkg::SUM_W'(0) - q) : q;
    endfunction

    function automatic result_beat_t predict_row(input logic newp, input logic peer,
                                                 input logic nul,
                                                 input logic [swrr_pkg::ARG_W-1:0] arg);
        result_beat_t r;
        r.value   = '0;
        r.is_null = 1'b0;
        if (newp)
        begin
            clear_partition_state();
        end
        rows_seen = bump(rows_seen);
        // first row of a partition always ranks 1, peer flag or not
        if (!peer || rows_seen == swrr_pkg::CNT_W'(1))
        begin
            rank_now = rows_seen;
        end
        if (at_first_row || !peer)
        begin
            dense_now    = bump(dense_now);
            at_first_row = 1'b0;
        end
        if (!nul)
        begin
            running_sum = add_clamped(running_sum, widen_arg(arg));
            seen_value  = 1'b1;
            values_seen = bump(values_seen);
        end
        case (model_mode)
            swrr_pkg::MODE_ROW_NUM: r.value = swrr_pkg::SUM_W'(rows_seen);
            swrr_pkg::MODE_RANK:    r.value = swrr_pkg::SUM_W'(rank_now);
            swrr_pkg::MODE_DENSE:   r.value = swrr_pkg::SUM_W'(dense_now);
            swrr_pkg::MODE_SUM:
            begin
                if (seen_value) r.value = running_sum;
                else            r.is_null = 1'b1;
            end
            swrr_pkg::MODE_AVG:
            begin
                if (seen_value) r.value = fixed_mean(running_sum, values_seen);
                else            r.is_null = 1'b1;
            end
            default:      r.is_null = 1'b1;   // codes 5..7 are unused
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: checks result beats first, then books the row beat taken
    // at the same edge. All sampled values are pre-edge since every driver
    // uses nonblocking updates.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [swrr_pkg::SUM_W-1:0] got,
                                   input logic [swrr_pkg::SUM_W-1:0] want);
        fail_count++;
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_beat_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat", res_ch.result_value, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (res_ch.result_value !== want.value)
                    begin
                        report_mismatch("result_value", res_ch.result_value, want.value);
                    end
                    if (res_ch.result_null !== want.is_null)
                    begin
                        report_mismatch("result_null",
                                        swrr_pkg::SUM_W'(res_ch.result_null),
                                        swrr_pkg::SUM_W'(want.is_null));
                    end
                end
            end
            if (row_ch.valid && row_ch.ready)
            begin
                pending_results.push_back(predict_row(row_ch.new_partition, row_ch.is_peer,
                                                      row_ch.arg_null, row_ch.arg_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver backpressure: random stall windows
    // ------------------------------------------------------------------
    bit recv_stalls_on = 1'b1;
    int stall_left     = 0;

    always @(posedge clk)
    begin
        if (!recv_stalls_on)
        begin
            res_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 19);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of 1..16 beats, gaps between bursts when enabled
    // ------------------------------------------------------------------
    bit sender_gaps_on = 1'b1;
    int burst_left     = 0;

    task automatic send_row(input logic newp, input logic peer, input logic nul,
                            input logic [swrr_pkg::ARG_W-1:0] arg);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
            if (sender_gaps_on && gap > 0)
            begin
                row_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        row_ch.valid         <= 1'b1;
        row_ch.new_partition <= newp;
        row_ch.is_peer       <= peer;
        row_ch.arg_null      <= nul;
        row_ch.arg_value     <= arg;
        do @(posedge clk); while (!row_ch.ready);
    endtask

    // Stop sending and wait until every booked result has come back.
    // The first edge lets the scoreboard book a beat taken just before.
    task automatic drain_results();
        row_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // APB write: setup beat, then access beat until pready.
    task automatic apb_write(input logic [swrr_pkg::PADDR_W-1:0] addr,
                             input logic [swrr_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == swrr_pkg::ADDR_FUNC_MODE)
        begin
            model_mode = data[swrr_pkg::MODE_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mode change only while idle; upper data bits are junk on purpose.
    task automatic set_mode(input logic [swrr_pkg::MODE_W-1:0] mode);
        logic [swrr_pkg::PDATA_W-1:0] data;
        drain_results();
        data = $urandom();
        data[swrr_pkg::MODE_W-1:0] = mode;
        apb_write(swrr_pkg::ADDR_FUNC_MODE, data);
    endtask

    function automatic logic [swrr_pkg::ARG_W-1:0] rand_arg();
        int s;
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3:
            begin
                s = $urandom_range(0, 200);
                return swrr_pkg::ARG_W'(s - 100);
            end
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset mode is row number; the very first row is a peer and must still
    // count as the partition's first row.
    task automatic test_row_number_after_reset();
        send_row(1'b0, 1'b1, 1'b0, 32'd3);
        send_row(1'b0, 1'b1, 1'b1, 32'd0);
        send_row(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    endtask

    // Ties share a rank then leave a gap; peer on a partition start ranks 1.
    task automatic test_rank();
        set_mode(swrr_pkg::MODE_RANK);
        send_row(1'b1, 1'b1, 1'b0, 32'd1);
        send_row(1'b0, 1'b1, 1'b0, 32'd1);
        send_row(1'b0, 1'b0, 1'b0, 32'd2);
        send_row(1'b0, 1'b1, 1'b1, 32'd2);
        send_row(1'b0, 1'b0, 1'b0, 32'd3);
        send_row(1'b1, 1'b1, 1'b0, 32'd4);
        send_row(1'b0, 1'b0, 1'b0, 32'd5);
    endtask

    task automatic test_dense_rank();
        set_mode(swrr_pkg::MODE_DENSE);
        send_row(1'b1, 1'b1, 1'b0, 32'd0);
        send_row(1'b0, 1'b1, 1'b0, 32'd0);
        send_row(1'b0, 1'b0, 1'b0, 32'd0);
        send_row(1'b0, 1'b1, 1'b0, 32'd0);
        send_row(1'b0, 1'b0, 1'b0, 32'd0);
    endtask

    // Leading nulls give null, then extremes of the argument accumulate.
    task automatic test_running_sum();
        set_mode(swrr_pkg::MODE_SUM);
        send_row(1'b1, 1'b0, 1'b1, 32'd5);
        send_row(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        send_row(1'b0, 1'b1, 1'b0, 32'h7FFF_FFFF);
        send_row(1'b0, 1'b0, 1'b0, 32'h8000_0000);
        send_row(1'b0, 1'b0, 1'b1, 32'h8000_0000);
    endtask

    // Negative means truncate toward zero; a new partition drops old values.
    task automatic test_running_average();
        set_mode(swrr_pkg::MODE_AVG);
        send_row(1'b1, 1'b0, 1'b1, 32'd9);
        send_row(1'b0, 1'b0, 1'b0, -32'sd7);
        send_row(1'b0, 1'b0, 1'b0, 32'd2);
        send_row(1'b0, 1'b0, 1'b1, 32'd100);
        send_row(1'b1, 1'b0, 1'b0, 32'h8000_0000);
        send_row(1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF);
        send_row(1'b1, 1'b1, 1'b1, 32'd1);
    endtask

    // Codes 5 and 7 give null; writes to any other address leave the mode alone.
    task automatic test_unused_modes_and_addresses();
        set_mode(MODE_SPARE_7);
        send_row(1'b0, 1'b0, 1'b0, 32'd11);
        set_mode(MODE_SPARE_5);
        send_row(1'b0, 1'b1, 1'b0, 32'd12);
        set_mode(swrr_pkg::MODE_SUM);
        for (int a = 1; a < (1 << swrr_pkg::PADDR_W); a++)
        begin
            apb_write(swrr_pkg::PADDR_W'(a),
                      {16'($urandom_range(0, 65535)), 16'd0}
                      | swrr_pkg::PDATA_W'(swrr_pkg::MODE_ROW_NUM));
        end
        send_row(1'b0, 1'b0, 1'b0, 32'd13);
    endtask

    // Mostly well-formed partitions: open with new_partition, peers in runs,
    // mixed nulls; a few noise rows with random flags.
    task automatic run_random_rows(input int n);
        int   sent;
        int   plen;
        int   null_pct;
        bit   noise;
        logic newp;
        logic peer;
        logic nul;
        sent = 0;
        while (sent < n)
        begin
            plen     = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            null_pct = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 40);
            for (int k = 0; k < plen && sent < n; k++)
            begin
                noise = ($urandom_range(0, 19) == 0);
                newp  = (k == 0);
                peer  = ($urandom_range(0, 99) < 40);
                if (noise)
                begin
                    newp = 1'($urandom_range(0, 1));
                    peer = 1'($urandom_range(0, 1));
                end
                nul = ($urandom_range(0, 99) < null_pct);
                send_row(newp, peer, nul, rand_arg());
                sent++;
            end
            // occasionally let the block run completely dry mid-stream
            if ($urandom_range(0, 49) == 0)
            begin
                drain_results();
            end
        end
    endtask

    task automatic test_random_phases();
        logic [swrr_pkg::MODE_W-1:0] phase_modes [13];
        phase_modes = '{swrr_pkg::MODE_ROW_NUM, swrr_pkg::MODE_AVG, swrr_pkg::MODE_SUM,
                        swrr_pkg::MODE_RANK, swrr_pkg::MODE_DENSE, MODE_SPARE_7,
                        swrr_pkg::MODE_AVG, swrr_pkg::MODE_RANK, MODE_SPARE_6,
                        swrr_pkg::MODE_SUM, swrr_pkg::MODE_DENSE, MODE_SPARE_5,
                        swrr_pkg::MODE_ROW_NUM};
        for (int p = 0; p < 13; p++)
        begin
            set_mode(phase_modes[p]);
            // phase 0 runs with no idling at all, phase 1 with both sides idling
            if (p == 0)
            begin
                sender_gaps_on = 1'b0;
                recv_stalls_on = 1'b0;
            end
            else if (p == 1)
            begin
                sender_gaps_on = 1'b1;
                recv_stalls_on = 1'b1;
            end
            else
            begin
                sender_gaps_on = ($urandom_range(0, 2) != 0);
                recv_stalls_on = ($urandom_range(0, 2) != 0);
            end
            run_random_rows((phase_modes[p] > swrr_pkg::MODE_AVG) ? 25 : 160);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        row_ch.valid         <= 1'b0;
        row_ch.new_partition <= 1'b0;
        row_ch.is_peer       <= 1'b0;
        row_ch.arg_null      <= 1'b0;
        row_ch.arg_value     <= '0;
        model_mode = swrr_pkg::MODE_ROW_NUM;
        clear_partition_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_row_number_after_reset();
        test_rank();
        test_dense_rank();
        test_running_sum();
        test_running_average();
        test_unused_modes_and_addresses();
        test_random_phases();

        drain_results();
        // catch any stray beat the block might still emit
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS sql_window_rank_and_running_aggregate");
        end
        else
        begin
            $display("FAIL sql_window_rank_and_running_aggregate");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with all-average phases
    // and maximum gaps and stalls.
    initial
    begin
        #30_000_000;
        $display("FAIL sql_window_rank_and_running_aggregate");
        $finish;
    end

endmodule
